// ----- sv/asev_pkg.sv -----
// Shared types and constants for the arcsine series pipeline.
package asev_pkg;

    localparam int unsigned QW        = 41;
    localparam int unsigned FRAC_GAP  = 10;
    localparam int unsigned ARG_W     = 32;
    localparam int unsigned MAG_W     = 31;
    localparam int unsigned SQ_W      = 61;

    localparam logic [MAG_W-1:0] ONE_Q30  = 31'd1073741824;
    localparam logic [MAG_W-1:0] ASIN_MAX = 31'd1686629713;

    // One item in flight between term stages; sum excludes the current term.
    typedef struct packed {
        logic          vld;
        logic          neg;
        logic [QW-1:0] x2;
        logic [QW-1:0] term;
        logic [QW-1:0] sum;
    } asev_lane_t;

endpackage

// ----- sv/asev_front.sv -----
// Input stages: sign split, magnitude clamp and x squared.
module asev_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic signed [asev_pkg::ARG_W-1:0] in_arg,
    output asev_pkg::asev_lane_t              lane_o
);

    logic                          neg_next;
    logic [asev_pkg::ARG_W-1:0]    abs_val;
    logic [asev_pkg::MAG_W-1:0]    mag_next;

    logic                          vld0_reg;
    logic                          neg0_reg;
    logic [asev_pkg::MAG_W-1:0]    mag0_reg;

    logic                          vld1_reg;
    logic                          neg1_reg;
    logic [asev_pkg::MAG_W-1:0]    mag1_reg;
    logic [asev_pkg::SQ_W-1:0]     sq1_reg;
    logic [asev_pkg::SQ_W-1:0]     sq1_next;

    always_comb begin
        neg_next = in_arg[asev_pkg::ARG_W-1];
        abs_val  = neg_next ? (~in_arg + 32'd1) : in_arg;
        if (abs_val > {1'b0, asev_pkg::ONE_Q30}) begin
            mag_next = asev_pkg::ONE_Q30;
        end else begin
            mag_next = abs_val[asev_pkg::MAG_W-1:0];
        end
    end

    assign sq1_next = 61'(mag0_reg) * 61'(mag0_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= in_vld;
            vld1_reg <= vld0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg0_reg <= neg_next;
            mag0_reg <= mag_next;
            neg1_reg <= neg0_reg;
            mag1_reg <= mag0_reg;
            sq1_reg  <= sq1_next;
        end
    end

    // term0 = |x| in Q.40; x^2 in Q.40 = mag^2 >> 20
    always_comb begin
        lane_o.vld  = vld1_reg;
        lane_o.neg  = neg1_reg;
        lane_o.x2   = sq1_reg[60:20];
        lane_o.term = {mag1_reg, 10'b0};
        lane_o.sum  = '0;
    end

endmodule

// ----- sv/asev_term.sv -----
// One series term: t = floor(floor(t * x^2 >> 40) * (2K-1)^2 / (2K(2K+1))), four stages.
module asev_term #(
    parameter int unsigned K = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  asev_pkg::asev_lane_t lane_i,
    output asev_pkg::asev_lane_t lane_o
);

    localparam int unsigned ODD = 2 * K - 1;
    localparam int unsigned A   = ODD * ODD;
    localparam int unsigned D   = (2 * K) * (2 * K + 1);
    localparam logic [85:0] NUMER = 86'(A) << 63;
    localparam logic [85:0] DEN   = 86'(D);
    // ceil(A * 2^63 / D): exact quotient for every numerator below 2^41
    localparam logic [85:0] QUOT  = (NUMER + DEN - 86'd1) / DEN;
    localparam logic [62:0] MAGIC = QUOT[62:0];
    localparam logic [30:0] M1    = MAGIC[62:32];
    localparam logic [31:0] M0    = MAGIC[31:0];

    localparam int unsigned QW = asev_pkg::QW;

    // stage 1: partial products of term * x^2
    logic          s1_vld_reg;
    logic          s1_neg_reg;
    logic [QW-1:0] s1_x2_reg;
    logic [QW-1:0] s1_sum_reg;
    logic [QW-1:0] s1_sum_next;
    logic [41:0]   s1_pp11_reg;
    logic [40:0]   s1_pp10_reg;
    logic [40:0]   s1_pp01_reg;
    logic [39:0]   s1_pp00_reg;

    // stage 2: truncated product p
    logic          s2_vld_reg;
    logic          s2_neg_reg;
    logic [QW-1:0] s2_x2_reg;
    logic [QW-1:0] s2_sum_reg;
    logic [QW-1:0] s2_p_reg;
    logic [81:0]   s2_full;

    // stage 3: partial products of p * MAGIC
    logic          s3_vld_reg;
    logic          s3_neg_reg;
    logic [QW-1:0] s3_x2_reg;
    logic [QW-1:0] s3_sum_reg;
    logic [51:0]   s3_q11_reg;
    logic [52:0]   s3_q10_reg;
    logic [50:0]   s3_q01_reg;
    logic [51:0]   s3_q00_reg;

    // stage 4: quotient = new term
    logic          s4_vld_reg;
    logic          s4_neg_reg;
    logic [QW-1:0] s4_x2_reg;
    logic [QW-1:0] s4_sum_reg;
    logic [QW-1:0] s4_term_reg;
    logic [103:0]  s4_prod;

    assign s1_sum_next = lane_i.sum + lane_i.term;

    assign s2_full = (82'(s1_pp11_reg) << 40) + (82'(s1_pp10_reg) << 20)
                   + (82'(s1_pp01_reg) << 20) + 82'(s1_pp00_reg);

    assign s4_prod = (104'(s3_q11_reg) << 52) + (104'(s3_q10_reg) << 20)
                   + (104'(s3_q01_reg) << 32) + 104'(s3_q00_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= lane_i.vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_neg_reg  <= lane_i.neg;
            s1_x2_reg   <= lane_i.x2;
            s1_sum_reg  <= s1_sum_next;
            s1_pp11_reg <= 42'(lane_i.term[40:20]) * 42'(lane_i.x2[40:20]);
            s1_pp10_reg <= 41'(lane_i.term[40:20]) * 41'(lane_i.x2[19:0]);
            s1_pp01_reg <= 41'(lane_i.term[19:0]) * 41'(lane_i.x2[40:20]);
            s1_pp00_reg <= 40'(lane_i.term[19:0]) * 40'(lane_i.x2[19:0]);

            s2_neg_reg  <= s1_neg_reg;
            s2_x2_reg   <= s1_x2_reg;
            s2_sum_reg  <= s1_sum_reg;
            s2_p_reg    <= s2_full[80:40];

            s3_neg_reg  <= s2_neg_reg;
            s3_x2_reg   <= s2_x2_reg;
            s3_sum_reg  <= s2_sum_reg;
            s3_q11_reg  <= 52'(s2_p_reg[40:20]) * 52'(M1);
            s3_q10_reg  <= 53'(s2_p_reg[40:20]) * 53'(M0);
            s3_q01_reg  <= 51'(s2_p_reg[19:0]) * 51'(M1);
            s3_q00_reg  <= 52'(s2_p_reg[19:0]) * 52'(M0);

            s4_neg_reg  <= s3_neg_reg;
            s4_x2_reg   <= s3_x2_reg;
            s4_sum_reg  <= s3_sum_reg;
            s4_term_reg <= s4_prod[103:63];
        end
    end

    always_comb begin
        lane_o.vld  = s4_vld_reg;
        lane_o.neg  = s4_neg_reg;
        lane_o.x2   = s4_x2_reg;
        lane_o.term = s4_term_reg;
        lane_o.sum  = s4_sum_reg;
    end

endmodule

// ----- sv/asev_back.sv -----
// Final sum, rescale, saturation, sign, and the output register with skid entry.
module asev_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  asev_pkg::asev_lane_t              lane_i,
    output logic                              pipe_en,
    output logic                              out_vld,
    input  logic                              out_rdy,
    output logic signed [asev_pkg::ARG_W-1:0] out_val
);

    logic                          b1_vld_reg;
    logic                          b1_neg_reg;
    logic [asev_pkg::QW-1:0]       b1_total_reg;

    logic [asev_pkg::MAG_W-1:0]    res_mag;
    logic [asev_pkg::MAG_W-1:0]    res_cap;
    logic [asev_pkg::ARG_W-1:0]    res_val;

    logic                          out_vld_reg;
    logic [asev_pkg::ARG_W-1:0]    out_val_reg;
    logic                          skid_vld_reg;
    logic [asev_pkg::ARG_W-1:0]    skid_val_reg;

    assign pipe_en = !skid_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            b1_vld_reg <= lane_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            b1_neg_reg   <= lane_i.neg;
            b1_total_reg <= lane_i.sum + lane_i.term;
        end
    end

    always_comb begin
        res_mag = b1_total_reg[asev_pkg::QW-1:asev_pkg::FRAC_GAP];
        if (res_mag > asev_pkg::ASIN_MAX) begin
            res_cap = asev_pkg::ASIN_MAX;
        end else begin
            res_cap = res_mag;
        end
        if (b1_neg_reg) begin
            res_val = ~{1'b0, res_cap} + 32'd1;
        end else begin
            res_val = {1'b0, res_cap};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (out_rdy) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (out_vld_reg && !out_rdy) begin
            if (b1_vld_reg) begin
                skid_vld_reg <= 1'b1;
            end
        end else begin
            out_vld_reg <= b1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (out_rdy) begin
                out_val_reg <= skid_val_reg;
            end
        end else if (out_vld_reg && !out_rdy) begin
            skid_val_reg <= res_val;
        end else begin
            out_val_reg <= res_val;
        end
    end

    assign out_vld = out_vld_reg;
    assign out_val = out_val_reg;

endmodule

// ----- sv/arcsin_series_evaluator_unit.sv -----
// Top level: arcsine by Maclaurin series, one pipelined stage group per term.
//
//   channel   ports                               payload
//   input     s_valid / s_ready / s_arg_x         x, signed Q1.30
//   result    m_valid / m_ready / m_asin_value    arcsin(x), signed Q1.30, saturated
//
// One item per cycle sustained while the output is not stalled. From acceptance to
// m_valid an item passes two front stages (clamp, square), four per term (two split multiplies,
// each followed by its partial-product sum), one final sum stage and the output register.
// aresetn is synchronous; it clears every valid bit, no clearing pass.
// A result stalled at the output parks the next item in a skid entry; the whole
// pipeline then holds until m_ready, and s_ready follows that skid entry.
module arcsin_series_evaluator_unit #(
    parameter int unsigned LAST_TERM = 501
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_arg_x,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_asin_value
);

    logic                 pipe_en;
    asev_pkg::asev_lane_t lane [0:LAST_TERM];

    assign s_ready = pipe_en;

    asev_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .in_vld  (s_valid),
        .in_arg  (s_arg_x),
        .lane_o  (lane[0])
    );

    for (genvar g = 1; g <= LAST_TERM; g++) begin : g_term
        asev_term #(
            .K (g)
        ) u_term (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (pipe_en),
            .lane_i  (lane[g-1]),
            .lane_o  (lane[g])
        );
    end

    asev_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .lane_i  (lane[LAST_TERM]),
        .pipe_en (pipe_en),
        .out_vld (m_valid),
        .out_rdy (m_ready),
        .out_val (m_asin_value)
    );

endmodule

// ----- bench/tb_arcsin_series_evaluator_unit.sv -----
// Testbench for the arcsine series pipeline: streams Q1.30 arguments and checks each Q1.30 result.
`timescale 1ns / 1ps

module tb_arcsin_series_evaluator_unit;

    localparam int unsigned TERMS       = 501;
    localparam int unsigned LATENCY     = 4 * TERMS + 3;
    localparam int unsigned RANDOM_ARGS = 1530;
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [31:0] arg;
        logic signed [31:0] asin;
    } asin_pending_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_FOUR,
        READY_MOSTLY
    } ready_mode_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_arg_x = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_asin_value;

    logic signed [31:0] arg_queue[$];
    asin_pending_t      asin_pending[$];
    logic               arg_taken = 1'b0;
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count = 0;
    int unsigned        burst_left = 0;
    int unsigned        gap_left = 0;
    int unsigned        ready_phase = 0;
    int unsigned        ready_tick = 0;
    ready_mode_t        ready_mode = READY_ALWAYS;

    arcsin_series_evaluator_unit #(
        .LAST_TERM(TERMS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_arg_x     (s_arg_x),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_asin_value(m_asin_value)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // (a * b) >> 40, truncated
    function automatic bit [63:0] q40_product(input bit [63:0] a, input bit [63:0] b);
        bit [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[103:40];
    endfunction

    function automatic logic signed [31:0] arcsin_series(input logic signed [31:0] x);
        bit                 neg;
        bit [63:0]          mag;
        bit [63:0]          term;
        bit [63:0]          x2;
        bit [63:0]          sum;
        bit [63:0]          odd;
        bit [63:0]          res;
        logic signed [31:0] asin;
        neg = x[31];
        mag = {32'd0, x};
        if (neg) mag = 64'h1_0000_0000 - mag;
        if (mag > asev_pkg::ONE_Q30) mag = asev_pkg::ONE_Q30;
        term = mag << asev_pkg::FRAC_GAP;
        x2   = q40_product(term, term);
        sum  = term;
        for (int unsigned k = 1; k <= TERMS; k++) begin
            odd  = 2 * k - 1;
            term = q40_product(term, x2);
            term = (term * odd * odd) / ((2 * k) * (2 * k + 1));
            sum += term;
        end
        res = sum >> asev_pkg::FRAC_GAP;
        if (res > asev_pkg::ASIN_MAX) res = asev_pkg::ASIN_MAX;
        asin = res[31:0];
        if (neg) asin = -asin;
        return asin;
    endfunction

    function automatic logic signed [31:0] pick_arg();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2, 3, 4: mag = $urandom_range(0, 32'h4000_0000);
            5:       mag = 32'h4000_0000 - $urandom_range(0, 4096);
            6:       mag = $urandom_range(0, 32'h0001_0000);
            7:       mag = 32'h4000_0000 + $urandom_range(0, 16);
            default: mag = $urandom >> $urandom_range(1, 31);
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Sender: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || arg_taken) begin
            if (gap_left != 0 || arg_queue.size() == 0) begin
                if (gap_left != 0) gap_left--;
                s_valid <= 1'b0;
            end else begin
                s_arg_x <= arg_queue.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 24);
                    gap_left   = $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Receiver: stall pattern is redrawn whenever its phase counter runs out
    always @(negedge aclk) begin
        if (ready_phase == 0) begin
            ready_mode  = ready_mode_t'($urandom_range(0, 3));
            ready_phase = $urandom_range(50, 600);
        end else begin
            ready_phase--;
        end
        ready_tick++;
        case (ready_mode)
            READY_ALWAYS:      m_ready <= 1'b1;
            READY_COIN:        m_ready <= 1'($urandom_range(0, 1));
            READY_ONE_IN_FOUR: m_ready <= (ready_tick % 4 == 0);
            default:           m_ready <= ($urandom_range(0, 6) != 0);
        endcase
    end

    // Monitor: predicts on accepted args, checks accepted results
    always @(posedge aclk) begin
        asin_pending_t pend;
        arg_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (asin_pending.size() == 0) begin
                report_mismatch($sformatf("result %0d with no item pending", m_asin_value));
            end else begin
                pend = asin_pending.pop_front();
                if (m_asin_value !== pend.asin)
                    report_mismatch($sformatf("x=%h asin_value got %0d want %0d",
                                              pend.arg, m_asin_value, pend.asin));
            end
        end
        if (aresetn && s_valid && s_ready)
            asin_pending.push_back('{arg: s_arg_x, asin: arcsin_series(s_arg_x)});
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic signed [31:0] corner_args[] = '{
            32'sh0000_0000, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh4000_0000,
            32'shC000_0000, 32'sh4000_0001, 32'shBFFF_FFFF, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh8000_0001, 32'sh2000_0000, 32'shE000_0000,
            32'sh3FFF_FFFF, 32'shC000_0001, 32'sh5555_5555, 32'shAAAA_AAAA,
            32'sh0000_FFFF, 32'shFFFF_0000, 32'sh2D41_3CCD, 32'shD2BE_C333,
            32'sh3FFF_0000, 32'sh0000_0400, 32'sh1234_5678
        };
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (corner_args[i]) arg_queue.push_back(corner_args[i]);

        for (int unsigned phase = 0; phase < 2; phase++) begin
            // hold off until the pipeline has drained
            while (arg_queue.size() != 0 || s_valid || asin_pending.size() != 0)
                @(negedge aclk);
            for (int unsigned i = 0; i < RANDOM_ARGS / 2; i++) arg_queue.push_back(pick_arg());
        end

        while (arg_queue.size() != 0 || s_valid || asin_pending.size() != 0)
            @(negedge aclk);
        repeat (LATENCY + 50) @(posedge aclk);

        if (mismatch_count == 0 && asin_pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
